// ===== src/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared word types, action codes and helpers for the LRU page replacement
// block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_PAGEIN = 2'd1;
  localparam logic [1:0] ACT_STUCK  = 2'd2;
  localparam logic [1:0] ACT_EVICT  = 2'd3;

  typedef struct packed {
    logic [5:0]  process;
    logic        active;
    logic [11:0] program_counter;
    logic [31:0] resident_mask;
    logic        pagein_accepted;
    logic        last_of_tick;
  } in_word_t;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] served_process;
    logic [4:0] victim_page;
  } out_word_t;

  // pages 32 and above never count as resident
  function automatic logic page_resident(input logic [31:0] mask, input logic [5:0] page);
    page_resident = !page[5] && mask[page[4:0]];
  endfunction

endpackage

// ===== src/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// Per-process LRU pager built around one timestamp memory with a registered
// read port.
// ----------------------------------------------------------------------------
// After reset the block sweeps the timestamp memory to zero, one entry a
// cycle (NUM_PROCESSES * PAGES_PER_PROCESS entries, 2048 by default), and
// holds busy high until the sweep is done. An accepted word then passes
// through page decode and stamp write when no eviction is needed, and
// also through a victim search when one is: the search reads one stored
// stamp per cycle through the single memory read port and ends early at a
// resident page's stamp of 1 or less. Each result is shown on out_data for
// exactly one cycle with out_valid high; the receiver cannot stall it, and a
// new word may be started in that same cycle.
module lru_page_replacement #(
  parameter int NUM_PROCESSES     = 64,
  parameter int PAGES_PER_PROCESS = 32,
  parameter int PAGE_BYTES        = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lrupr_pkg::in_word_t  in_data,
  output logic                 out_valid,
  output lrupr_pkg::out_word_t out_data
);
  import lrupr_pkg::*;

  localparam int DEPTH  = NUM_PROCESSES * PAGES_PER_PROCESS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SCAN_N = (PAGES_PER_PROCESS < 32) ? PAGES_PER_PROCESS : 32;
  localparam int CNT_W  = $clog2(SCAN_N + 1);
  localparam int DIV_L  = $clog2(PAGE_BYTES);
  localparam int DIV_S  = 12 + DIV_L;
  localparam logic [28:0] RECIP =
    29'(((64'd1 << DIV_S) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));
  localparam logic [31:0] RES_MASK =
    (SCAN_N == 32) ? 32'hFFFF_FFFF : 32'((64'd1 << SCAN_N) - 64'd1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_DECODE = 5'b00100,
    ST_STAMP  = 5'b01000,
    ST_SCAN   = 5'b10000
  } state_t;

  logic [31:0] mem [DEPTH];

  state_t          state_r, state_nxt;
  in_word_t        in_r, in_nxt;
  logic [11:0]     page_r, page_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [CNT_W-1:0] pg_r, pg_nxt;
  logic [CNT_W-1:0] cmp_pg_r, cmp_pg_nxt;
  logic            vld_r, vld_nxt;
  logic [32:0]     best_r, best_nxt;
  logic [4:0]      victim_r, victim_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [31:0]     tick_r, tick_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_data_r, out_data_nxt;
  logic [31:0]     rd_data_r;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [31:0]     mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;

  logic [28:0]     prod;
  logic            proc_ok;
  logic            page_ok;
  logic [AW-1:0]   base_c;
  logic            any_res;
  logic            hit;
  logic            finish;
  logic [1:0]      fin_act;
  logic [4:0]      fin_victim;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign prod    = 29'(in_r.program_counter) * RECIP;
  assign proc_ok = 9'(in_r.process) < 9'(NUM_PROCESSES);
  assign page_ok = 13'(page_r) < 13'(PAGES_PER_PROCESS);
  assign base_c  = AW'(32'(in_r.process) * 32'(PAGES_PER_PROCESS));
  assign any_res = |(in_r.resident_mask & RES_MASK);
  assign hit     = vld_r && page_resident(in_r.resident_mask, 6'(cmp_pg_r)) &&
                   ({1'b0, rd_data_r} < best_r);

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    page_nxt      = page_r;
    base_nxt      = base_r;
    pg_nxt        = pg_r;
    cmp_pg_nxt    = cmp_pg_r;
    vld_nxt       = 1'b0;
    best_nxt      = best_r;
    victim_nxt    = victim_r;
    clr_nxt       = clr_r;
    tick_nxt      = tick_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = 32'd0;
    mem_re        = 1'b0;
    mem_raddr     = base_r + AW'(pg_r);
    finish        = 1'b0;
    fin_act       = ACT_NONE;
    fin_victim    = 5'd0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          in_nxt    = in_data;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        page_nxt  = 12'(prod >> DIV_S);
        state_nxt = ST_STAMP;
      end
      ST_STAMP: begin
        if (in_r.active && proc_ok && page_ok) begin
          mem_we    = 1'b1;
          mem_waddr = base_c + AW'(page_r);
          mem_wdata = tick_r;
          if (page_resident(in_r.resident_mask, 6'(page_r))) begin
            finish = 1'b1;
          end else if (in_r.pagein_accepted) begin
            finish  = 1'b1;
            fin_act = ACT_PAGEIN;
          end else if (!any_res) begin
            finish  = 1'b1;
            fin_act = ACT_STUCK;
          end else begin
            base_nxt   = base_c;
            pg_nxt     = '0;
            best_nxt   = {1'b0, tick_r} + 33'd1;
            victim_nxt = 5'd0;
            state_nxt  = ST_SCAN;
          end
        end else begin
          finish = 1'b1;
        end
      end
      ST_SCAN: begin
        if (pg_r < CNT_W'(SCAN_N)) begin
          mem_re     = 1'b1;
          pg_nxt     = pg_r + CNT_W'(1);
          cmp_pg_nxt = pg_r;
          vld_nxt    = 1'b1;
        end
        if (hit) begin
          best_nxt   = {1'b0, rd_data_r};
          victim_nxt = 5'(cmp_pg_r);
        end
        if ((hit && rd_data_r <= 32'd1) ||
            (vld_r && cmp_pg_r == CNT_W'(SCAN_N - 1))) begin
          finish     = 1'b1;
          fin_act    = ACT_EVICT;
          fin_victim = hit ? 5'(cmp_pg_r) : victim_r;
          vld_nxt    = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt                   = ST_IDLE;
      out_valid_nxt               = 1'b1;
      out_data_nxt.action         = fin_act;
      out_data_nxt.served_process = in_r.process;
      out_data_nxt.victim_page    = fin_victim;
      if (in_r.last_of_tick && tick_r != 32'hFFFF_FFFF) begin
        tick_nxt = tick_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      tick_r      <= 32'd1;
      out_valid_r <= 1'b0;
      vld_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    page_r     <= page_nxt;
    base_r     <= base_nxt;
    pg_r       <= pg_nxt;
    cmp_pg_r   <= cmp_pg_nxt;
    best_r     <= best_nxt;
    victim_r   <= victim_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

endmodule

// ===== dv/lru_page_replacement_tb.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement_tb
// Self-checking bench for the per-process LRU pager. A scoreboard keeps its
// own tick counter and timestamp table, predicts the action and victim of
// every accepted word and checks each strobed result in order. Stimulus is a
// short directed part followed by random requests biased toward a few hot
// processes, so that stamp histories build up and victim searches run deep.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;
  import lrupr_pkg::*;

  localparam int NPROC       = 64;
  localparam int NPAGE       = 32;
  localparam int PBYTES      = 128;
  localparam int N_RANDOM    = 1930;
  localparam int QUIET_TAIL  = 300;
  localparam int STALL_LIMIT = 20000;

  class pager_scoreboard;
    bit [31:0] tick;
    bit [31:0] stamps [NPROC*NPAGE];
    out_word_t awaited [$];
    int mismatches;

    function new();
      tick = 32'd1;
      foreach (stamps[i]) stamps[i] = '0;
      mismatches = 0;
    endfunction

    function bit is_resident(input logic [31:0] m, input int unsigned pg);
      return (pg < 32) && m[pg];
    endfunction

    function void note_input(input in_word_t w);
      out_word_t exp_w;
      int unsigned page;
      int unsigned base;
      int unsigned victim;
      bit any;
      bit [32:0] best;
      exp_w = '0;
      exp_w.action = ACT_NONE;
      exp_w.served_process = w.process;
      victim = 0;
      if (w.active && w.process < NPROC) begin
        page = w.program_counter / PBYTES;
        if (page < NPAGE) begin
          base = w.process * NPAGE;
          stamps[base + page] = tick;
          if (!is_resident(w.resident_mask, page)) begin
            if (w.pagein_accepted) begin
              exp_w.action = ACT_PAGEIN;
            end else begin
              any = 1'b0;
              for (int unsigned pg = 0; pg < NPAGE; pg++)
                if (is_resident(w.resident_mask, pg)) any = 1'b1;
              if (!any) begin
                exp_w.action = ACT_STUCK;
              end else begin
                exp_w.action = ACT_EVICT;
                best = {1'b0, tick} + 33'd1;
                for (int unsigned pg = 0; pg < NPAGE; pg++) begin
                  if (is_resident(w.resident_mask, pg) &&
                      {1'b0, stamps[base + pg]} < best) begin
                    best = {1'b0, stamps[base + pg]};
                    victim = pg;
                    if (stamps[base + pg] <= 32'd1) break;
                  end
                end
              end
            end
          end
        end
      end
      exp_w.victim_page = victim[4:0];
      if (w.last_of_tick && tick != 32'hFFFF_FFFF) tick++;
      awaited.push_back(exp_w);
    endfunction

    function void check_result(input out_word_t got);
      out_word_t exp_w;
      if (awaited.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: action %0d proc %0d victim %0d",
                   got.action, got.served_process, got.victim_page);
        mismatches++;
        return;
      end
      exp_w = awaited.pop_front();
      if (got.action !== exp_w.action || got.served_process !== exp_w.served_process ||
          got.victim_page !== exp_w.victim_page) begin
        if (mismatches < 10)
          $display("mismatch: expected action %0d proc %0d victim %0d, got %0d %0d %0d",
                   exp_w.action, exp_w.served_process, exp_w.victim_page,
                   got.action, got.served_process, got.victim_page);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_data;
  logic      out_valid;
  out_word_t out_data;

  pager_scoreboard sb;
  int stall_cycles;

  lru_page_replacement #(
    .NUM_PROCESSES    (NPROC),
    .PAGES_PER_PROCESS(NPAGE),
    .PAGE_BYTES       (PBYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_input(in_data);
      if (out_valid) sb.check_result(out_data);
      if ((start && !busy) || out_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic in_word_t mk(input logic [5:0] proc, input logic act,
                                  input logic [11:0] pc, input logic [31:0] mask,
                                  input logic acc, input logic last);
    in_word_t w;
    w.process = proc;
    w.active = act;
    w.program_counter = pc;
    w.resident_mask = mask;
    w.pagein_accepted = acc;
    w.last_of_tick = last;
    return w;
  endfunction

  function automatic in_word_t rand_request();
    in_word_t w;
    logic [31:0] mask;
    int unsigned page;
    w.process = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 3))
                                            : 6'($urandom_range(0, NPROC - 1));
    w.active = ($urandom_range(0, 9) != 0);
    w.program_counter = 12'($urandom_range(0, 4095));
    case ($urandom_range(0, 9))
      0:       mask = '0;
      1:       mask = '1;
      2, 3:    mask = $urandom() & $urandom() & $urandom();
      4, 5:    mask = $urandom() | $urandom();
      default: mask = $urandom();
    endcase
    page = w.program_counter / PBYTES;
    if ($urandom_range(0, 9) < 7) mask[page[4:0]] = 1'b0;
    w.resident_mask = mask;
    w.pagein_accepted = ($urandom_range(0, 9) < 4);
    w.last_of_tick = ($urandom_range(0, 3) == 0);
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    @(negedge clk);
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= in_word_t'({$urandom(), $urandom()});
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    stall_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(mk(6'd63, 1'b0, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_word(mk(6'd0,  1'b1, 12'h000, 32'h0000_0000, 1'b1, 1'b0));
    send_word(mk(6'd0,  1'b1, 12'h07F, 32'h0000_0001, 1'b0, 1'b0));
    send_word(mk(6'd0,  1'b1, 12'h080, 32'h0000_0000, 1'b0, 1'b0));
    send_word(mk(6'd1,  1'b1, 12'h000, 32'hFFFF_FFFE, 1'b0, 1'b1));
    send_word(mk(6'd63, 1'b1, 12'hFFF, 32'h7FFF_FFFF, 1'b0, 1'b1));
    send_word(mk(6'd2,  1'b1, 12'h280, 32'h0000_0000, 1'b1, 1'b1));
    send_word(mk(6'd2,  1'b1, 12'h180, 32'h0000_0000, 1'b1, 1'b1));
    send_word(mk(6'd2,  1'b1, 12'h200, 32'h0000_0000, 1'b1, 1'b1));
    send_word(mk(6'd2,  1'b1, 12'h000, 32'h0000_0038, 1'b0, 1'b0));
    send_word(mk(6'd2,  1'b1, 12'h080, 32'h0000_0030, 1'b0, 1'b1));
    send_word(mk(6'd2,  1'b1, 12'h000, 32'h0000_0039, 1'b0, 1'b0));
    send_word(mk(6'd3,  1'b1, 12'h000, 32'h8000_0000, 1'b0, 1'b0));
    send_word(mk(6'd3,  1'b1, 12'hF80, 32'h8000_0000, 1'b0, 1'b1));
    send_word(mk(6'd3,  1'b1, 12'h000, 32'h8000_0000, 1'b0, 1'b0));
    send_word(mk(6'd42, 1'b0, 12'h000, 32'h0000_0000, 1'b0, 1'b1));
    send_word(mk(6'd21, 1'b1, 12'hAAA, 32'h5555_5555, 1'b0, 1'b0));
    send_word(mk(6'd21, 1'b1, 12'h555, 32'hAAAA_AAAA, 1'b1, 1'b1));
    send_word(mk(6'd21, 1'b1, 12'h800, 32'hFFFE_FFFF, 1'b0, 1'b1));
    send_word(mk(6'd21, 1'b1, 12'h000, 32'hFFFF_FFFE, 1'b0, 1'b0));
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i < N_RANDOM - QUIET_TAIL && $urandom_range(0, 5) == 0)
        hold_off($urandom_range(1, 17));
      if (i == N_RANDOM / 2) drain();
      send_word(rand_request());
    end

    drain();
    repeat (64) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/lrupr_pkg.sv
src/lru_page_replacement.sv
dv/lru_page_replacement_tb.sv
